// ===== src/twlf_pkg.sv =====
// ----------------------------------------------------------------------------
// twlf_pkg: shared types and constants for the text width line fit block
// Character classes, queue entry, width table and status structs.
// ----------------------------------------------------------------------------
package twlf_pkg;

  localparam int CHAR_W = 8;   // raw text byte
  localparam int FONT_W = 10;  // font size register
  localparam int ROOM_W = 22;  // line room, running width
  localparam int CW_W   = 10;  // one character width
  localparam int LEN_W  = 13;  // break length result
  localparam int ADDR_W = 1;   // configuration register index
  localparam int QDEPTH = 4;   // front to back queue depth
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [ROOM_W-1:0] WIDTH_MAX  = '1;
  localparam logic [FONT_W-1:0] FONT_RESET = 10'd16;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_FONT_PX   = 1'd0;
  localparam logic [ADDR_W-1:0] REG_LINE_ROOM = 1'd1;

  // character class as decided by the front
  typedef enum logic [1:0] {
    CLS_SPACE,
    CLS_LOWER,
    CLS_UPPER,
    CLS_OTHER
  } char_cls_t;

  // one queue entry
  typedef struct packed {
    char_cls_t cls;
    logic      last;
  } twlf_item_t;

  // per-class width for the current font size
  typedef struct packed {
    logic [CW_W-1:0] space_w;
    logic [CW_W-1:0] lower_w;
    logic [CW_W-1:0] upper_w;
    logic [CW_W-1:0] other_w;
  } twlf_wtab_t;

  // back stage status
  typedef struct packed {
    logic pop;
    logic pop_last;
  } twlf_bstat_t;

endpackage

// ===== src/twlf_front.sv =====
// ----------------------------------------------------------------------------
// twlf_front: byte classifier
// Sorts each incoming byte into a width class and forms the queue entry.
// ----------------------------------------------------------------------------
module twlf_front
  import twlf_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  input  logic              final_char,
  output twlf_item_t        item
);

  char_cls_t cls;

  // class decode: tab, newline, vt, ff, cr and space are whitespace
  always_comb begin
    if ((char_code >= 8'd9 && char_code <= 8'd13) || char_code == 8'd32) begin
      cls = CLS_SPACE;
    end else if (char_code >= 8'd97 && char_code <= 8'd122) begin
      cls = CLS_LOWER;
    end else if (char_code >= 8'd65 && char_code <= 8'd90) begin
      cls = CLS_UPPER;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign item.cls  = cls;
  assign item.last = final_char;

endmodule

// ===== src/twlf_queue.sv =====
// ----------------------------------------------------------------------------
// twlf_queue: short queue between front and back
// Four-entry register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module twlf_queue
  import twlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  twlf_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output twlf_item_t head
);

  twlf_item_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // pointer and fill count update
  always_comb begin
    wptr_nxt = do_push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

// ===== src/twlf_back.sv =====
// ----------------------------------------------------------------------------
// twlf_back: width accumulator and line fit counter
// Adds each character width, tracks the longest fitting prefix and loads
// the output register on the last byte of a run.
// ----------------------------------------------------------------------------
module twlf_back
  import twlf_pkg::*;
#(
  parameter int MAX_CHARS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  twlf_item_t        q_item,
  output logic              q_pop,
  input  twlf_wtab_t        wtab,
  input  logic [ROOM_W-1:0] line_room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ROOM_W-1:0] out_total,
  output logic [LEN_W-1:0]  out_break,
  output logic              out_too_long,
  output twlf_bstat_t       stat
);

  localparam int CNT_W = $clog2(MAX_CHARS + 1);

  logic [ROOM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  fit_r, fit_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r;
  logic [ROOM_W-1:0] out_total_r;
  logic [LEN_W-1:0]  out_break_r;
  logic              out_too_long_r;
  logic [CW_W-1:0]   cw;
  logic [ROOM_W:0]   full;
  logic              pop;

  // a byte that ends a run waits until the output register can take a result
  assign pop   = q_valid && (!q_item.last || !out_valid_r || out_ready);
  assign q_pop = pop;

  // width of this byte
  always_comb begin
    case (q_item.cls)
      CLS_SPACE: cw = wtab.space_w;
      CLS_LOWER: cw = wtab.lower_w;
      CLS_UPPER: cw = wtab.upper_w;
      CLS_OTHER: cw = wtab.other_w;
      default:   cw = wtab.other_w;
    endcase
  end

  assign full = {1'b0, sum_r} + (ROOM_W + 1)'(cw);

  // run state update
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    fit_nxt = fit_r;
    ovf_nxt = ovf_r;
    if (cnt_r >= CNT_W'(MAX_CHARS)) begin
      ovf_nxt = 1'b1;
    end else begin
      if (fit_r == cnt_r && line_room != '0 && full <= {1'b0, line_room}) begin
        fit_nxt = fit_r + CNT_W'(1);
      end
      sum_nxt = full[ROOM_W] ? WIDTH_MAX : full[ROOM_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // run state registers, cleared after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      fit_r <= '0;
      ovf_r <= 1'b0;
    end else if (pop) begin
      if (q_item.last) begin
        sum_r <= '0;
        cnt_r <= '0;
        fit_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        fit_r <= fit_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && q_item.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      out_total_r    <= sum_nxt;
      out_break_r    <= LEN_W'(fit_nxt);
      out_too_long_r <= ovf_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_total     = out_total_r;
  assign out_break     = out_break_r;
  assign out_too_long  = out_too_long_r;
  assign stat.pop      = pop;
  assign stat.pop_last = pop && q_item.last;

endmodule

// ===== src/text_width_line_fit.sv =====
// ----------------------------------------------------------------------------
// text_width_line_fit: text run width measurer with line fit
// Measures a byte stream by character class and reports total width and
// break length at the end of each run.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while its queue has room, and on the
// byte marked with tlast returns the run's saturated total width and the length
// of the longest prefix that fits line_room. A classifier feeds a four-entry
// queue; the back stage adds one character width and does one compare per
// cycle, which is what sets the rate. The last byte is registered in the queue,
// popped by the back stage (when nothing waits ahead of it in the queue) and
// its result loaded into an output register, from which it can be taken. Bytes
// that do not end a run keep flowing while a result waits; a last byte waits
// in the queue until the held result is taken, and once the queue is full
// the input stalls. Runs longer than MAX_CHARS bytes set too_long and are
// measured over their first MAX_CHARS bytes. Configuration writes belong
// between runs, with the block idle.
// ----------------------------------------------------------------------------
module text_width_line_fit
  import twlf_pkg::*;
#(
  parameter int MAX_CHARS = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [ROOM_W-1:0] cfg_wdata,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] char_code
  input  logic              in_tlast,   // final_char
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // [21:0] total_width, [34:22] break_length
  output logic              out_tuser   // too_long
);

  twlf_wtab_t        wtab_r;
  logic [ROOM_W-1:0] line_room_r;
  twlf_item_t        f_item;
  twlf_item_t        q_head;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  twlf_bstat_t       bstat;
  logic [ROOM_W-1:0] res_total;
  logic [LEN_W-1:0]  res_break;

  // per-class widths from a font size; x/5 as multiply by 3277 and shift 14
  function automatic twlf_wtab_t calc_wtab(input logic [FONT_W-1:0] f);
    logic [12:0] f5;
    logic [12:0] f7;
    logic [11:0] f3;
    logic [23:0] p;
    twlf_wtab_t  t;
    f5 = {3'b0, f} * 13'd5;
    f7 = {3'b0, f} * 13'd7;
    f3 = {2'b0, f} * 12'd3;
    p  = {12'b0, f3} * 24'd3277;
    t.space_w = {2'b0, f[FONT_W-1:2]};
    t.lower_w = f5[12:3];
    t.upper_w = f7[12:3];
    t.other_w = p[23:14];
    return t;
  endfunction

  // configuration registers; width table recomputed on a font write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wtab_r      <= calc_wtab(FONT_RESET);
      line_room_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FONT_PX:   wtab_r      <= calc_wtab(cfg_wdata[FONT_W-1:0]);
        REG_LINE_ROOM: line_room_r <= cfg_wdata;
        default:       line_room_r <= line_room_r;
      endcase
    end
  end

  assign in_tready = rst_n && !q_full;

  twlf_front u_front (
    .char_code  (in_tdata),
    .final_char (in_tlast),
    .item       (f_item)
  );

  twlf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  twlf_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_head),
    .q_pop        (q_pop),
    .wtab         (wtab_r),
    .line_room    (line_room_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_total    (res_total),
    .out_break    (res_break),
    .out_too_long (out_tuser),
    .stat         (bstat)
  );

  assign out_tdata = {5'b0, res_break, res_total};

`ifndef SYNTHESIS
  // a transferred byte is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> q_valid)
    else $error("accepted byte missing from queue");

  // the last byte of a run always produces a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.pop_last |=> out_tvalid)
    else $error("last byte did not load a result");

  // a taken result with no new last byte clears the output register
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !bstat.pop_last) |=> !out_tvalid)
    else $error("result repeated");

  // the back stage never loads a new result over a stalled one
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !bstat.pop_last)
    else $error("last byte popped over a stalled result");
`endif

endmodule
